[sv/bsb_pkg.sv]
package bsb_pkg;

   // fixed field widths
   localparam int FRAC_BITS  = 16;
   localparam int U_W        = 22;
   localparam int VAL_W      = 17;
   localparam int IDX_W      = 4;
   localparam int DEG_W      = 3;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // internal widths: clamped degree up to 15, clamped count up to 127
   localparam int PD_W    = 4;
   localparam int PN_W    = 7;
   localparam int KNOT_W  = 8;
   localparam int NUM_W   = KNOT_W + FRAC_BITS;
   localparam int PROD_W  = NUM_W + VAL_W;
   localparam int Y_W     = PROD_W - FRAC_BITS;
   localparam int DIV_W   = 4;
   localparam int RECIP_S = 29;
   localparam int RECIP_W = RECIP_S + 1;
   localparam int QP_W    = Y_W + RECIP_W;
   localparam int Q_W     = QP_W - RECIP_S;

   localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1 << FRAC_BITS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'b1;

   localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;
   localparam logic [CNT_W-1:0] COUNT_RESET  = 5'd4;

   // one classified item between front and back
   typedef struct packed {
      logic [U_W-1:0]  u;
      logic [PD_W-1:0] p;
      logic [PN_W-1:0] n;
      logic            err;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_INIT,
      ST_RD0,
      ST_LD0,
      ST_RD,
      ST_MUL,
      ST_DIV,
      ST_WR,
      ST_EMIT
   } back_state_type;

   // open uniform knot value at position i
   function automatic logic [KNOT_W-1:0] knot_at(input logic [KNOT_W-1:0] i,
                                                 input logic [PD_W-1:0] p,
                                                 input logic [PN_W-1:0] n);
      logic [KNOT_W-1:0] pk;
      logic [KNOT_W-1:0] nk;
      pk = KNOT_W'(p);
      nk = KNOT_W'(n);
      if (i <= pk) begin
         return '0;
      end else if (i >= nk) begin
         return nk - pk;
      end else begin
         return i - pk;
      end
   endfunction

   // ceil(2^RECIP_S / d), exact quotient for dividends below 2^Y_W
   function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd1:    r = RECIP_W'(536870912);
         4'd2:    r = RECIP_W'(268435456);
         4'd3:    r = RECIP_W'(178956971);
         4'd4:    r = RECIP_W'(134217728);
         4'd5:    r = RECIP_W'(107374183);
         4'd6:    r = RECIP_W'(89478486);
         4'd7:    r = RECIP_W'(76695845);
         4'd8:    r = RECIP_W'(67108864);
         4'd9:    r = RECIP_W'(59652324);
         4'd10:   r = RECIP_W'(53687092);
         4'd11:   r = RECIP_W'(48806447);
         4'd12:   r = RECIP_W'(44739243);
         4'd13:   r = RECIP_W'(41297763);
         4'd14:   r = RECIP_W'(38347923);
         4'd15:   r = RECIP_W'(35791395);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[sv/bsb_front.sv]
module bsb_front import bsb_pkg::*; #(
   parameter int MAX_POINTS = 16,
   parameter int MAX_DEGREE = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  start,
   input  logic [U_W-1:0]        req_param_u,
   input  logic                  q_full,
   output logic                  push,
   output job_type               job
);

   logic [DEG_W-1:0] degree_ff, degree_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PD_W-1:0]  p_eff;
   logic [PN_W-1:0]  n_eff;

   // configuration registers
   always_comb begin
      degree_in = degree_ff;
      count_in  = count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEGREE:      degree_in = csr_write_data[DEG_W-1:0];
            CSR_POINT_COUNT: count_in  = csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         count_ff  <= COUNT_RESET;
      end else begin
         degree_ff <= degree_in;
         count_ff  <= count_in;
      end
   end

   // clamp and classify
   always_comb begin
      p_eff = (PD_W'(degree_ff) > PD_W'(MAX_DEGREE)) ? PD_W'(MAX_DEGREE) : PD_W'(degree_ff);
      n_eff = (PN_W'(count_ff) > PN_W'(MAX_POINTS)) ? PN_W'(MAX_POINTS) : PN_W'(count_ff);
      job.u   = req_param_u;
      job.p   = p_eff;
      job.n   = n_eff;
      job.err = (n_eff < PN_W'(2)) || (n_eff <= PN_W'(p_eff));
   end

   assign push = start & ~q_full;

endmodule

[sv/bsb_queue.sv]
module bsb_queue import bsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type pop_data
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/bsb_back.sv]
module bsb_back import bsb_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             pop,
   output logic             rsp_strobe,
   output logic [IDX_W-1:0] rsp_basis_index,
   output logic [VAL_W-1:0] rsp_basis_value,
   output logic             rsp_last_value,
   output logic             rsp_config_error
);

   localparam int AW = $clog2(MAX_POINTS);

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [PN_W-1:0]   j_ff, j_in;
   logic [PD_W-1:0]   i_ff, i_in;
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [VAL_W-1:0]  nxt_ff, nxt_in;
   logic [PROD_W-1:0] prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic [QP_W-1:0]   q1_ff, q1_in, q2_ff, q2_in;
   logic [VAL_W-1:0]  rd_data_ff;
   logic              out_pend_ff, out_pend_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;

   logic [VAL_W-1:0] basis_work [MAX_POINTS];
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [VAL_W-1:0] wr_data;

   logic [KNOT_W-1:0] j8, i8, kj, kj1, kji1, kji2, kend, d1, d2;
   logic [NUM_W-1:0]  u_ext, a1, b2, hi1, kend_fx, num1, num2;
   logic [PN_W-1:0]   j_next;
   logic              has_next, last_j, in_span, end_hit;
   logic [Q_W:0]      sum;
   logic [VAL_W-1:0]  new_val;

   // knot values and distances for the current entry
   always_comb begin
      j8       = KNOT_W'(j_ff);
      i8       = KNOT_W'(i_ff);
      kj       = knot_at(j8, job_ff.p, job_ff.n);
      kj1      = knot_at(j8 + KNOT_W'(1), job_ff.p, job_ff.n);
      kji1     = knot_at(j8 + i8 + KNOT_W'(1), job_ff.p, job_ff.n);
      kji2     = knot_at(j8 + i8 + KNOT_W'(2), job_ff.p, job_ff.n);
      kend     = knot_at(KNOT_W'(job_ff.n) + KNOT_W'(job_ff.p), job_ff.p, job_ff.n);
      d1       = kji1 - kj;
      d2       = kji2 - kj1;
      u_ext    = NUM_W'(job_ff.u);
      a1       = {kj, FRAC_BITS'(0)};
      hi1      = {kj1, FRAC_BITS'(0)};
      b2       = {kji2, FRAC_BITS'(0)};
      kend_fx  = {kend, FRAC_BITS'(0)};
      num1     = (u_ext > a1) ? (u_ext - a1) : '0;
      num2     = (b2 > u_ext) ? (b2 - u_ext) : '0;
      j_next   = j_ff + PN_W'(1);
      has_next = (j_next < job_ff.n);
      last_j   = (j_next == job_ff.n);
      in_span  = (u_ext >= a1) && (u_ext < hi1);
      end_hit  = (u_ext == kend_fx) && last_j;
      sum      = (Q_W + 1)'(q1_ff[QP_W-1:RECIP_S]) + (Q_W + 1)'(q2_ff[QP_W-1:RECIP_S]);
      new_val  = (sum > (Q_W + 1)'(ONE_FX)) ? ONE_FX : sum[VAL_W-1:0];
   end

   // sequencer: error result, or indicator fill, passes over the row, then readout
   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      prod1_in    = prod1_ff;
      prod2_in    = prod2_ff;
      q1_in       = q1_ff;
      q2_in       = q2_ff;
      out_pend_in = 1'b0;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      out_err_in  = out_err_ff;
      pop         = 1'b0;
      rd_addr     = j_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_data     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               job_in   = job;
               j_in     = '0;
               i_in     = '0;
               state_in = job.err ? ST_ERR : ST_INIT;
            end
         end
         ST_ERR: begin
            out_pend_in = 1'b1;
            out_idx_in  = '0;
            out_last_in = 1'b1;
            out_err_in  = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = (in_span || end_hit) ? ONE_FX : '0;
            if (last_j) begin
               j_in     = '0;
               state_in = (job_ff.p == '0) ? ST_EMIT : ST_RD0;
            end else begin
               j_in = j_next;
            end
         end
         ST_RD0: begin
            rd_addr  = '0;
            state_in = ST_LD0;
         end
         ST_LD0: begin
            cur_in   = rd_data_ff;
            state_in = ST_RD;
         end
         ST_RD: begin
            rd_addr  = has_next ? j_next[AW-1:0] : j_ff[AW-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            nxt_in   = rd_data_ff;
            prod1_in = (d1 != '0) ? PROD_W'(num1) * PROD_W'(cur_ff) : '0;
            prod2_in = (has_next && (d2 != '0)) ? PROD_W'(num2) * PROD_W'(rd_data_ff) : '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q1_in    = QP_W'(prod1_ff[PROD_W-1:FRAC_BITS]) * QP_W'(recip(d1[DIV_W-1:0]));
            q2_in    = QP_W'(prod2_ff[PROD_W-1:FRAC_BITS]) * QP_W'(recip(d2[DIV_W-1:0]));
            state_in = ST_WR;
         end
         ST_WR: begin
            wr_en   = 1'b1;
            wr_data = new_val;
            cur_in  = nxt_ff;
            if (last_j) begin
               j_in = '0;
               if ((i_ff + PD_W'(1)) == job_ff.p) begin
                  state_in = ST_EMIT;
               end else begin
                  i_in     = i_ff + PD_W'(1);
                  state_in = ST_RD0;
               end
            end else begin
               j_in     = j_next;
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            rd_addr     = j_ff[AW-1:0];
            out_pend_in = 1'b1;
            out_idx_in  = j_ff[IDX_W-1:0];
            out_last_in = last_j;
            out_err_in  = 1'b0;
            if (last_j) begin
               state_in = ST_IDLE;
            end else begin
               j_in = j_next;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_pend_ff <= out_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      q1_ff       <= q1_in;
      q2_ff       <= q2_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   // working row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         basis_work[j_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= basis_work[rd_addr];
   end

   // result port
   assign rsp_strobe       = out_pend_ff;
   assign rsp_basis_index  = out_idx_ff;
   assign rsp_basis_value  = out_err_ff ? '0 : rd_data_ff;
   assign rsp_last_value   = out_last_ff;
   assign rsp_config_error = out_err_ff;

   // checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_pend_ff && !out_err_ff) |-> (PN_W'(out_idx_ff) < job_ff.n))
      else $error("result index beyond point count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == ST_INIT) || (state_ff == ST_WR)))
      else $error("row written outside fill or pass");

   a_pop_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> ((state_ff == ST_ERR) || (state_ff == ST_INIT)))
      else $error("item taken without starting work");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) |=> (out_pend_ff && out_err_ff && out_last_ff))
      else $error("error result not delivered");

endmodule

[sv/bspline_basis_eval.sv]
// channel  | ports                                     | handshake
// ---------+-------------------------------------------+------------------------------
// request  | start, busy, req_param_u                  | transfer when start && !busy
// result   | rsp_strobe, rsp_basis_* , rsp_last_value, | one cycle per strobe,
//          | rsp_config_error                          | no back-pressure
// csr      | csr_write_en, csr_index, csr_write_data   | write when csr_write_en
//
// one u takes an indicator fill, p passes over the row, then a readout (n points,
// degree p); each entry per pass is read, multiplied, divided and written back
// through the single-port working row; a configuration error gives one result
// a two-entry queue sits between request and engine; busy is high when it is full
// synchronous active-high reset clears the queue, the engine and the registers
// results cannot be stalled by the receiver
module bspline_basis_eval import bsb_pkg::*; #(
   parameter int MAX_POINTS = 16,
   parameter int MAX_DEGREE = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [U_W-1:0]        req_param_u,
   output logic                  rsp_strobe,
   output logic [IDX_W-1:0]      rsp_basis_index,
   output logic [VAL_W-1:0]      rsp_basis_value,
   output logic                  rsp_last_value,
   output logic                  rsp_config_error,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic    push, q_full, q_not_empty, pop;
   job_type push_job, pop_job;

   // accept and classify
   bsb_front #(
      .MAX_POINTS(MAX_POINTS),
      .MAX_DEGREE(MAX_DEGREE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .start          (start),
      .req_param_u    (req_param_u),
      .q_full         (q_full),
      .push           (push),
      .job            (push_job)
   );

   // item queue
   bsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (pop_job)
   );

   // recurrence engine
   bsb_back #(
      .MAX_POINTS(MAX_POINTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_not_empty),
      .job              (pop_job),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_basis_index  (rsp_basis_index),
      .rsp_basis_value  (rsp_basis_value),
      .rsp_last_value   (rsp_last_value),
      .rsp_config_error (rsp_config_error)
   );

   assign busy = q_full;

endmodule

[tb/bspline_basis_eval_tb.sv]
`timescale 1ns / 100ps

module bspline_basis_eval_tb;
   import bsb_pkg::*;

   localparam int PTS_LIMIT   = 16;
   localparam int DEG_LIMIT   = 7;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 600;

   typedef enum logic [1:0] {CHK_MODEL, CHK_CFG_ERR, CHK_ZERO} check_kind_type;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
      logic             last;
      logic             err;
   } basis_rsp_type;

   typedef struct {
      logic [DEG_W-1:0] deg;
      logic [CNT_W-1:0] cnt;
      logic [U_W-1:0]   u;
      check_kind_type   kind;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [U_W-1:0]        req_param_u;
   logic                  rsp_strobe;
   logic [IDX_W-1:0]      rsp_basis_index;
   logic [VAL_W-1:0]      rsp_basis_value;
   logic                  rsp_last_value;
   logic                  rsp_config_error;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   basis_rsp_type    basis_expected[$];
   logic [DEG_W-1:0] cur_degree;
   logic [CNT_W-1:0] cur_count;
   int               mismatch_count;
   int               stall_cycles;
   int               sender_idle_pct;

   bspline_basis_eval u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_param_u(req_param_u), .rsp_strobe(rsp_strobe),
      .rsp_basis_index(rsp_basis_index), .rsp_basis_value(rsp_basis_value),
      .rsp_last_value(rsp_last_value), .rsp_config_error(rsp_config_error),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // append one expected result at the tail
   function automatic void expect_rsp(basis_rsp_type r);
      basis_expected.insert(basis_expected.size(), r);
   endfunction

   // open uniform knot vector
   function automatic longint unsigned knot_pos(longint unsigned i, longint unsigned p,
                                                longint unsigned n);
      if (i <= p) return 0;
      if (i >= n) return n - p;
      return i - p;
   endfunction

   // cox-de boor basis row for one u, or a configuration error result, queued as expected results
   function automatic void predict_basis(logic [U_W-1:0] u_in);
      longint unsigned one_fx, u, p, n, kj, d1, kb, d2, num, t1, t2, s;
      longint unsigned row[PTS_LIMIT];
      longint unsigned nxt[PTS_LIMIT];
      basis_rsp_type r;
      one_fx = 64'd1 << FRAC_BITS;
      u = u_in;
      p = (cur_degree > DEG_LIMIT) ? DEG_LIMIT : cur_degree;
      n = (cur_count > PTS_LIMIT) ? PTS_LIMIT : cur_count;
      if (n < 2 || n <= p) begin
         r = '{idx: '0, val: '0, last: 1'b1, err: 1'b1};
         expect_rsp(r);
         return;
      end
      // degree zero indicator functions
      for (int j = 0; j < n; j++)
         row[j] = (u >= knot_pos(j, p, n) * one_fx && u < knot_pos(j + 1, p, n) * one_fx)
                  ? one_fx : 0;
      if (u == knot_pos(n + p, p, n) * one_fx) row[n-1] = one_fx;
      // raise the degree one pass at a time
      for (int i = 0; i < p; i++) begin
         for (int j = 0; j < n; j++) begin
            kj = knot_pos(j, p, n);
            d1 = knot_pos(j + i + 1, p, n) - kj;
            t1 = 0;
            t2 = 0;
            if (d1 != 0) begin
               num = (u > kj * one_fx) ? u - kj * one_fx : 0;
               t1 = (num * row[j]) / (d1 << FRAC_BITS);
            end
            if (j + 1 < n) begin
               kb = knot_pos(j + i + 2, p, n);
               d2 = kb - knot_pos(j + 1, p, n);
               if (d2 != 0) begin
                  num = (kb * one_fx > u) ? kb * one_fx - u : 0;
                  t2 = (num * row[j+1]) / (d2 << FRAC_BITS);
               end
            end
            s = t1 + t2;
            nxt[j] = (s > one_fx) ? one_fx : s;
         end
         for (int j = 0; j < n; j++) row[j] = nxt[j];
      end
      for (int j = 0; j < n; j++) begin
         r = '{idx: IDX_W'(j), val: VAL_W'(row[j]), last: (j == n - 1), err: 1'b0};
         expect_rsp(r);
      end
   endfunction

   // result check and stall watchdog
   always @(posedge clock) begin
      basis_rsp_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_strobe) begin
            if (basis_expected.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected transfer idx=%0d val=%0d last=%0b err=%0b",
                           rsp_basis_index, rsp_basis_value, rsp_last_value,
                           rsp_config_error);
            end else begin
               e = basis_expected.pop_front();
               if (e.idx !== rsp_basis_index || e.val !== rsp_basis_value ||
                   e.last !== rsp_last_value || e.err !== rsp_config_error) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch exp %0d %0d %0b %0b got %0d %0d %0b %0b",
                              e.idx, e.val, e.last, e.err, rsp_basis_index,
                              rsp_basis_value, rsp_last_value, rsp_config_error);
               end
            end
         end
      end
   end

   task automatic wait_drain();
      while (basis_expected.size() != 0) @(posedge clock);
   endtask

   // both registers, written only with nothing in flight
   task automatic set_config(logic [DEG_W-1:0] d, logic [CNT_W-1:0] c);
      start <= 1'b0;
      @(posedge clock);
      wait_drain();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_DEGREE;
      csr_write_data <= CSR_DATA_W'(d);
      @(posedge clock);
      csr_index      <= CSR_POINT_COUNT;
      csr_write_data <= CSR_DATA_W'(c);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_degree = d;
      cur_count  = c;
   endtask

   // one request transfer; start stays high for a following item
   task automatic send_param(logic [U_W-1:0] u, check_kind_type kind);
      int n;
      basis_rsp_type r;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start       <= 1'b1;
      req_param_u <= u;
      do @(posedge clock); while (busy);
      n = (cur_count > PTS_LIMIT) ? PTS_LIMIT : cur_count;
      case (kind)
         CHK_CFG_ERR: begin
            r = '{idx: '0, val: '0, last: 1'b1, err: 1'b1};
            expect_rsp(r);
         end
         CHK_ZERO: begin
            for (int j = 0; j < n; j++) begin
               r = '{idx: IDX_W'(j), val: '0, last: (j == n - 1), err: 1'b0};
               expect_rsp(r);
            end
         end
         default: predict_basis(u);
      endcase
   endtask

   stim_row_type directed_rows[] = '{
      '{3'd3, 5'd4,  22'd0,          CHK_MODEL},
      '{3'd3, 5'd4,  22'd32768,      CHK_MODEL},
      '{3'd3, 5'd4,  22'd65536,      CHK_MODEL},
      '{3'd3, 5'd4,  22'h3FFFFF,     CHK_ZERO},
      '{3'd0, 5'd0,  22'd5,          CHK_CFG_ERR},
      '{3'd1, 5'd1,  22'd0,          CHK_CFG_ERR},
      '{3'd7, 5'd7,  22'd70000,      CHK_CFG_ERR},
      '{3'd2, 5'd2,  22'd100,        CHK_CFG_ERR},
      '{3'd0, 5'd31, 22'd0,          CHK_MODEL},
      '{3'd0, 5'd31, 22'd1048575,    CHK_MODEL},
      '{3'd0, 5'd31, 22'd1048576,    CHK_MODEL},
      '{3'd1, 5'd2,  22'd32768,      CHK_MODEL},
      '{3'd1, 5'd2,  22'd65536,      CHK_MODEL},
      '{3'd7, 5'd16, 22'd0,          CHK_MODEL},
      '{3'd7, 5'd16, 22'd300001,     CHK_MODEL},
      '{3'd7, 5'd16, 22'd589824,     CHK_MODEL},
      '{3'd7, 5'd16, 22'd4128768,    CHK_ZERO},
      '{3'd7, 5'd31, 22'd589823,     CHK_MODEL},
      '{3'd7, 5'd8,  22'd65535,      CHK_MODEL},
      '{3'd5, 5'd17, 22'd2796202,    CHK_ZERO},
      '{3'd4, 5'd12, 22'd200000,     CHK_MODEL},
      '{3'd2, 5'd16, 22'd851968,     CHK_MODEL}
   };

   initial begin
      logic [DEG_W-1:0] d;
      logic [CNT_W-1:0] c;
      int               span, pick;
      logic [U_W-1:0]   u;
      reset          = 1'b1;
      start          = 1'b0;
      req_param_u    = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_DEGREE;
      csr_write_data = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      sender_idle_pct = 29;
      cur_degree     = DEGREE_RESET;
      cur_count      = COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table, registers rewritten when the row asks for a new setting
      foreach (directed_rows[k]) begin
         if (directed_rows[k].deg != cur_degree || directed_rows[k].cnt != cur_count)
            set_config(directed_rows[k].deg, directed_rows[k].cnt);
         send_param(directed_rows[k].u, directed_rows[k].kind);
      end

      // random part: sender idles 29%, then 60%, then never
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 60 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            d = DEG_W'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 85)
               c = CNT_W'($urandom_range(d + 1 < 2 ? 2 : d + 1, 16));
            else c = CNT_W'($urandom_range(0, 31));
            set_config(d, c);
            span = ((c > PTS_LIMIT ? PTS_LIMIT : c) > d) ?
                   ((c > PTS_LIMIT ? PTS_LIMIT : c) - d) : 1;
            repeat (8) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) u = U_W'($urandom_range(0, span << FRAC_BITS));
               else if (pick < 82) u = U_W'($urandom_range(0, span)) << FRAC_BITS;
               else u = U_W'($urandom);
               send_param(u, CHK_MODEL);
            end
         end
      end
      start <= 1'b0;
      wait_drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && basis_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
